/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files; hbp_outq includes them.
// ASSERT_PROP checks a property on every rising clock edge outside reset.
// ASSERT_NEXT checks that a condition holds in the cycle after its trigger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/hbp_pkg.sv */
package hbp_pkg;

	// Fixed field widths
	localparam int KIND_W  = 2;
	localparam int SYM_W   = 8;
	localparam int LEN_W   = 5;
	localparam int CODE_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int USED_W  = 4;
	localparam int OFF_W   = 3;
	localparam int ACC_W   = CODE_W + BYTE_W;
	localparam int TOTAL_W = 5;

	localparam logic [USED_W-1:0] FULL_BYTE = USED_W'(BYTE_W);

	// Output queue of result groups (at most one group per item, up to two bytes)
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = QPTR_W + 1;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FINISH = 2'd2
	} hbp_kind_t;

	// One code table entry as stored in the RAM
	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} hbp_entry_t;

	// Results caused by one item
	typedef struct packed {
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic              two;
		logic [USED_W-1:0] used;
		logic              last;
	} hbp_group_t;

endpackage

/* hw/rtl/huffman_bit_packer.sv */
// Huffman bit packer. Load items (kind 0) write the code table entry of one
// symbol; lengths above the code limit saturate and code bits above the length
// are dropped. Encode items (kind 1) look the symbol up in a one-port-read code
// RAM and pack its code LSB first into a byte accumulator; every filled byte
// is a result with used_bits 8. A finish item (kind 2) returns the partial byte
// with its bit count and last set, even when empty, and clears the
// accumulator. Kind 3 and out-of-range load or encode items are dropped.
// An item is taken every cycle while the four-group output queue has room;
// any result it makes passes the registered table read and the queue
// register before it is offered. The output port moves one byte a cycle
// while out_stall is low and sets the sustained rate; a two-byte code sends
// its bytes in turn. Encoding a never-loaded symbol gives undefined bytes.
module huffman_bit_packer
	import hbp_pkg::*;
#(
	parameter int SYMBOLS      = 256,
	parameter int MAX_CODE_LEN = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [KIND_W-1:0] kind,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [LEN_W-1:0]  code_length,
	input  logic [CODE_W-1:0] code_bits,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic [USED_W-1:0] used_bits,
	output logic              last
);

	localparam int ADDR_W  = $clog2(SYMBOLS);
	localparam int LEN_LIM = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	logic              in_acc;
	logic              in_range;
	logic              do_load;
	logic              do_enc;
	logic              do_fin;
	logic [LEN_W-1:0]  len_sat;
	logic [CODE_W:0]   mask;
	hbp_entry_t        wr_entry;
	hbp_entry_t        rd_entry;
	logic              enc_s1;
	logic              fin_s1;
	logic              push;
	logic              room;
	hbp_group_t        grp;
	logic [ADDR_W-1:0] addr;

	assign in_stall = !room;
	assign in_acc   = in_valid && !in_stall;
	assign in_range = ({1'b0, symbol} < (SYM_W+1)'(SYMBOLS));
	assign addr     = symbol[ADDR_W-1:0];

	// Decode the item kind
	always_comb begin
		do_load = 1'b0;
		do_enc  = 1'b0;
		do_fin  = 1'b0;
		unique case (hbp_kind_t'(kind))
			KIND_LOAD:   do_load = in_acc && in_range;
			KIND_ENCODE: do_enc  = in_acc && in_range;
			KIND_FINISH: do_fin  = in_acc;
			default:     ;
		endcase
	end

	// Saturate the length and drop stray code bits
	always_comb begin
		len_sat       = (code_length > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : code_length;
		mask          = ((CODE_W+1)'(1) << len_sat) - (CODE_W+1)'(1);
		wr_entry.len  = len_sat;
		wr_entry.code = code_bits & mask[CODE_W-1:0];
	end

	hbp_ram #(
		.WIDTH ($bits(hbp_entry_t)),
		.DEPTH (SYMBOLS)
	) u_table (
		.clk   (clk),
		.we    (do_load),
		.waddr (addr),
		.wdata (wr_entry),
		.re    (do_enc),
		.raddr (addr),
		.rdata (rd_entry)
	);

	// Track the item in lookup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_s1 <= 1'b0;
			fin_s1 <= 1'b0;
		end else begin
			enc_s1 <= do_enc;
			fin_s1 <= do_fin;
		end
	end

	hbp_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.enc_s1 (enc_s1),
		.fin_s1 (fin_s1),
		.entry  (rd_entry),
		.push   (push),
		.grp    (grp)
	);

	hbp_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.grp       (grp),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.used_bits (used_bits),
		.last      (last)
	);

endmodule

/* hw/rtl/hbp_ram.sv */
module hbp_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, register the read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/hbp_packer.sv */
module hbp_packer
	import hbp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       enc_s1,
	input  logic       fin_s1,
	input  hbp_entry_t entry,
	output logic       push,
	output hbp_group_t grp
);

	logic [BYTE_W-1:0]  partial_q;
	logic [OFF_W-1:0]   offset_q;
	logic [ACC_W-1:0]   acc;
	logic [TOTAL_W-1:0] total;
	logic [1:0]         nbytes;
	logic               enc_live;
	logic [BYTE_W-1:0]  partial_nxt;

	// Append the code above the pending bits
	always_comb begin
		acc      = (ACC_W'(entry.code) << offset_q) | ACC_W'(partial_q);
		total    = TOTAL_W'(offset_q) + entry.len;
		nbytes   = total[TOTAL_W-1:OFF_W];
		enc_live = enc_s1 && (entry.len != '0);
		case (nbytes)
			2'd0:    partial_nxt = acc[BYTE_W-1:0];
			2'd1:    partial_nxt = acc[2*BYTE_W-1:BYTE_W];
			default: partial_nxt = acc[3*BYTE_W-1:2*BYTE_W];
		endcase
	end

	// Build the result group of this item
	always_comb begin
		push     = fin_s1 || (enc_live && (nbytes != 2'd0));
		grp.b0   = fin_s1 ? partial_q : acc[BYTE_W-1:0];
		grp.b1   = acc[2*BYTE_W-1:BYTE_W];
		grp.two  = enc_s1 && nbytes[1];
		grp.used = fin_s1 ? USED_W'(offset_q) : FULL_BYTE;
		grp.last = fin_s1;
	end

	// Advance or clear the accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			offset_q  <= '0;
		end else if (fin_s1) begin
			partial_q <= '0;
			offset_q  <= '0;
		end else if (enc_live) begin
			partial_q <= partial_nxt;
			offset_q  <= total[OFF_W-1:0];
		end
	end

endmodule

/* hw/rtl/hbp_outq.sv */
`include "assert_macros.svh"

module hbp_outq
	import hbp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hbp_group_t        grp,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [BYTE_W-1:0] out_byte,
	output logic [USED_W-1:0] used_bits,
	output logic              last
);

	hbp_group_t        q_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QLVL_W-1:0] level_q;
	logic              sel_q;
	hbp_group_t        head;
	logic              pop_byte;
	logic              pop_grp;

	// Present the current byte of the head group
	always_comb begin
		head      = q_q[rd_ptr_q];
		out_valid = (level_q != '0);
		out_byte  = sel_q ? head.b1 : head.b0;
		used_bits = sel_q ? FULL_BYTE : head.used;
		last      = sel_q ? 1'b0 : head.last;
		pop_byte  = out_valid && !out_stall;
		pop_grp   = pop_byte && (sel_q || !head.two);
		// Keep one slot free for the item now in lookup
		room      = ({1'b0, level_q} + (QLVL_W+1)'(push)) < (QLVL_W+1)'(QDEPTH);
	end

	// Store pushed groups
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= grp;
		end
	end

	// Advance pointers, level and byte select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
			sel_q    <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_grp) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				sel_q    <= 1'b0;
			end else if (pop_byte) begin
				sel_q <= 1'b1;
			end
			level_q <= level_q + QLVL_W'(push) - QLVL_W'(pop_grp);
		end
	end

	`ASSERT_PROP(a_no_overflow, clk, arst_n, push |-> (level_q < QLVL_W'(QDEPTH)), "queue overflow")
	`ASSERT_PROP(a_sel_two, clk, arst_n, sel_q |-> (out_valid && head.two), "second byte of a one-byte group")
	`ASSERT_NEXT(a_level_track, clk, arst_n, 1'b1, level_q == $past(level_q) + QLVL_W'($past(push)) - QLVL_W'($past(pop_grp)), "level mismatch")
	`ASSERT_NEXT(a_hold_on_stall, clk, arst_n, out_valid && out_stall, out_valid && (sel_q == $past(sel_q)), "stalled item moved")

endmodule
